>>> rtl/core/circular_deque_of_points_top_macros.svh
// Assertion macros for the deque RTL.
`ifndef CIRCULAR_DEQUE_OF_POINTS_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_OF_POINTS_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked while out of reset.
`define CDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, checked while out of reset.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`else

`define CDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int SUM_W  = IDX_W + 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 6;
    localparam int FILL_W = 7;
    localparam int CRD_W  = 16;
    localparam int WORD_W = 2 * CRD_W;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic signed [CRD_W-1:0] NONE_COORD = 16'hFFFF;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        REQ_PUSH_FRONT = 4'd0,
        REQ_PUSH_BACK  = 4'd1,
        REQ_POP_FRONT  = 4'd2,
        REQ_POP_BACK   = 4'd3,
        REQ_PEEK_FRONT = 4'd4,
        REQ_PEEK_BACK  = 4'd5,
        REQ_PEEK_AT    = 4'd6,
        REQ_CLEAR      = 4'd7,
        REQ_CONTAINS   = 4'd8
    } req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic [1:0]              status;
        logic                    found;
        logic [FILL_W-1:0]       fill;
    } res_t;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(DEPTH - 1))
            return '0;
        else
            return i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        if (i == '0)
            return IDX_W'(DEPTH - 1);
        else
            return i - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] h,
                                                  input logic [IDX_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = {1'b0, h} + {1'b0, off};
        if (s >= SUM_W'(DEPTH))
            s = s - SUM_W'(DEPTH);
        return s[IDX_W-1:0];
    endfunction

endpackage

>>> rtl/core/cdq_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one registered read port.
module cdq_ram #(
    parameter int DEPTH_P  = 64,
    parameter int WIDTH_P  = 32,
    parameter int ADDR_W_P = $clog2(DEPTH_P)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W_P-1:0] wr_addr,
    input  logic [WIDTH_P-1:0]  wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W_P-1:0] rd_addr,
    output logic [WIDTH_P-1:0]  rd_data
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/cdq_ctrl.sv
`timescale 1ns / 1ps
`include "circular_deque_of_points_top_macros.svh"

// Request sequencer: pointer and count upkeep, store access and contains scan.
module cdq_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [3:0]                        req_type,
    input  logic signed [cdq_pkg::CRD_W-1:0]  point_x,
    input  logic signed [cdq_pkg::CRD_W-1:0]  point_y,
    input  logic [cdq_pkg::POS_W-1:0]         position,
    output logic                              ram_wr_en,
    output logic [cdq_pkg::IDX_W-1:0]         ram_wr_addr,
    output logic [cdq_pkg::WORD_W-1:0]        ram_wr_data,
    output logic                              ram_rd_en,
    output logic [cdq_pkg::IDX_W-1:0]         ram_rd_addr,
    input  logic [cdq_pkg::WORD_W-1:0]        ram_rd_data,
    output logic                              res_valid,
    output cdq_pkg::res_t                     res,
    input  logic                              res_take
);

    cdq_pkg::state_t                 state_reg, state_next;
    logic [cdq_pkg::IDX_W-1:0]       head_reg, head_next;
    logic [cdq_pkg::IDX_W-1:0]       tail_reg, tail_next;
    logic [cdq_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [cdq_pkg::CNT_W-1:0]       iss_reg, iss_next;
    logic [cdq_pkg::WORD_W-1:0]      word_reg, word_next;
    cdq_pkg::res_t                   res_reg, res_next;
    logic                            full;
    logic                            accept;

    assign full   = (count_reg == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
    assign accept = req_valid && !req_stall;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        iss_next    = iss_reg;
        word_next   = word_reg;
        res_next    = res_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = head_reg;
        ram_wr_data = {point_y, point_x};
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;
        req_stall   = (state_reg != cdq_pkg::S_IDLE);
        res_valid   = (state_reg == cdq_pkg::S_RESP);

        unique case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next      = cdq_pkg::S_RESP;
                    word_next       = {point_y, point_x};
                    res_next.x      = '0;
                    res_next.y      = '0;
                    res_next.status = cdq_pkg::STAT_DONE;
                    res_next.found  = 1'b0;

                    unique case (req_type) inside
                        cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_next.status = cdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_wr_en = 1'b1;
                                if (count_reg == '0)
                                begin
                                    ram_wr_addr = '0;
                                    head_next   = '0;
                                    tail_next   = '0;
                                end
                                else if (req_type == cdq_pkg::REQ_PUSH_FRONT)
                                begin
                                    ram_wr_addr = cdq_pkg::idx_prev(head_reg);
                                    head_next   = cdq_pkg::idx_prev(head_reg);
                                end
                                else
                                begin
                                    ram_wr_addr = cdq_pkg::idx_next(tail_reg);
                                    tail_next   = cdq_pkg::idx_next(tail_reg);
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_PEEK_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = cdq_pkg::STAT_EMPTY;
                                res_next.x      = cdq_pkg::NONE_COORD;
                                res_next.y      = cdq_pkg::NONE_COORD;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = head_reg;
                                state_next  = cdq_pkg::S_READ;
                                if (req_type == cdq_pkg::REQ_POP_FRONT)
                                begin
                                    count_next = count_reg - 1'b1;
                                    if (count_reg != cdq_pkg::CNT_W'(1))
                                    begin
                                        head_next = cdq_pkg::idx_next(head_reg);
                                    end
                                end
                            end
                        end
                        cdq_pkg::REQ_POP_BACK, cdq_pkg::REQ_PEEK_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = cdq_pkg::STAT_EMPTY;
                                res_next.x      = cdq_pkg::NONE_COORD;
                                res_next.y      = cdq_pkg::NONE_COORD;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = tail_reg;
                                state_next  = cdq_pkg::S_READ;
                                if (req_type == cdq_pkg::REQ_POP_BACK)
                                begin
                                    count_next = count_reg - 1'b1;
                                    if (count_reg != cdq_pkg::CNT_W'(1))
                                    begin
                                        tail_next = cdq_pkg::idx_prev(tail_reg);
                                    end
                                end
                            end
                        end
                        cdq_pkg::REQ_PEEK_AT:
                        begin
                            if (cdq_pkg::CMP_W'(position) >= cdq_pkg::CMP_W'(count_reg))
                            begin
                                res_next.status = cdq_pkg::STAT_EMPTY;
                                res_next.x      = cdq_pkg::NONE_COORD;
                                res_next.y      = cdq_pkg::NONE_COORD;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = cdq_pkg::wrap_add(head_reg,
                                                  cdq_pkg::IDX_W'(position));
                                state_next  = cdq_pkg::S_READ;
                            end
                        end
                        cdq_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            head_next  = '0;
                            tail_next  = '0;
                        end
                        cdq_pkg::REQ_CONTAINS:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = head_reg;
                                iss_next    = cdq_pkg::CNT_W'(1);
                                state_next  = cdq_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    res_next.fill = cdq_pkg::FILL_W'(count_next);
                end
            end
            cdq_pkg::S_READ:
            begin
                res_next.x = ram_rd_data[cdq_pkg::CRD_W-1:0];
                res_next.y = ram_rd_data[cdq_pkg::WORD_W-1:cdq_pkg::CRD_W];
                state_next = cdq_pkg::S_RESP;
            end
            cdq_pkg::S_SCAN:
            begin
                // compare the entry fetched last cycle, fetch the following one
                if (ram_rd_data == word_reg)
                begin
                    res_next.found = 1'b1;
                    state_next     = cdq_pkg::S_RESP;
                end
                else if (iss_reg == count_reg)
                begin
                    state_next = cdq_pkg::S_RESP;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cdq_pkg::wrap_add(head_reg,
                                      iss_reg[cdq_pkg::IDX_W-1:0]);
                    iss_next    = iss_reg + 1'b1;
                end
            end
            cdq_pkg::S_RESP:
            begin
                if (res_take)
                begin
                    state_next = cdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            iss_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            iss_reg   <= iss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

    `CDQ_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH))
    `CDQ_ASSERT_IMPLY(a_single_entry, clk, rst_n, count_reg == cdq_pkg::CNT_W'(1),
        head_reg == tail_reg)
    `CDQ_ASSERT_IMPLY(a_scan_range, clk, rst_n, state_reg == cdq_pkg::S_SCAN,
        iss_reg != '0 && iss_reg <= count_reg)
    `CDQ_ASSERT_NEXT(a_full_push_holds, clk, rst_n,
        accept && full && (req_type == cdq_pkg::REQ_PUSH_FRONT ||
                           req_type == cdq_pkg::REQ_PUSH_BACK),
        $stable(count_reg) && $stable(head_reg) && $stable(tail_reg))
    `CDQ_ASSERT_IMPLY(a_no_rw_clash, clk, rst_n, ram_wr_en, !ram_rd_en)

endmodule

>>> rtl/core/circular_deque_of_points_top.sv
`timescale 1ns / 1ps
// Path, accept to result word: push, clear and unknown requests go straight to the
// result state, pop and peek that find an entry pass a read state first, and contains
// scans entries (at most the count) until a match or the last one. One request word is
// in flight at a time; the next word is taken once the result has left the sequencer.
// Reset (rst_n, async, active low) clears head, tail, count and all handshake state;
// the point store keeps no reset and no clearing pass is run.

module circular_deque_of_points_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [3:0]                        req_type,
    input  logic signed [cdq_pkg::CRD_W-1:0]  point_x,
    input  logic signed [cdq_pkg::CRD_W-1:0]  point_y,
    input  logic [cdq_pkg::POS_W-1:0]         position,
    // response channel
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic signed [cdq_pkg::CRD_W-1:0]  out_x,
    output logic signed [cdq_pkg::CRD_W-1:0]  out_y,
    output logic [1:0]                        status,
    output logic                              found,
    output logic [cdq_pkg::FILL_W-1:0]        fill_count
);

    logic                          ram_wr_en;
    logic [cdq_pkg::IDX_W-1:0]     ram_wr_addr;
    logic [cdq_pkg::WORD_W-1:0]    ram_wr_data;
    logic                          ram_rd_en;
    logic [cdq_pkg::IDX_W-1:0]     ram_rd_addr;
    logic [cdq_pkg::WORD_W-1:0]    ram_rd_data;

    logic                          res_valid;
    cdq_pkg::res_t                 res;
    logic                          res_take;

    logic                          rsp_valid_reg, rsp_valid_next;
    cdq_pkg::res_t                 rsp_reg;

    // Point store: one word per entry, x in the low half, y in the high half.
    // A push writes; pops, peeks and contains read; never both in one cycle, so
    // no read-during-write forwarding is needed.
    cdq_ram #(
        .DEPTH_P (cdq_pkg::DEPTH),
        .WIDTH_P (cdq_pkg::WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer: decodes the request, keeps head/tail/count and runs the scan.
    cdq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .point_x     (point_x),
        .point_y     (point_y),
        .position    (position),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    // Output register: take a finished result whenever the slot is empty or
    // being drained this cycle, so the sequencer is freed for the next word
    // while the consumer holds the previous one.
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            // drop the word once the consumer has taken it
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload holds while stalled: it only loads on a hand-off.
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign out_x      = rsp_reg.x;
    assign out_y      = rsp_reg.y;
    assign status     = rsp_reg.status;
    assign found      = rsp_reg.found;
    assign fill_count = rsp_reg.fill;

endmodule
